// ===== rtl/lpd_pkg.sv =====
// package for the length prefix deframer: codes, record layout and defaults
package lpd_pkg;

  localparam int ID_W        = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int CONN_DEF    = 256;
  localparam int CONN_ID_MAX = 256;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  // per-connection phase
  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_START = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [LEN_W-1:0]   count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/lpd_if.sv =====
// valid/ready channel interfaces for the deframer input and result streams
interface lpd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [lpd_pkg::ID_W-1:0]  conn_id;
  logic [lpd_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output op, output conn_id, output data_byte, input ready);
  modport sink   (input valid, input op, input conn_id, input data_byte, output ready);
endinterface

interface lpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::ID_W-1:0]   out_conn;
  logic [lpd_pkg::BYTE_W-1:0] payload_byte;
  logic                       first_byte;
  logic                       last_byte;
  logic                       empty_packet;
  logic                       aborted;

  modport source (output valid, output out_conn, output payload_byte, output first_byte,
                  output last_byte, output empty_packet, output aborted, input ready);
  modport sink   (input valid, input out_conn, input payload_byte, input first_byte,
                  input last_byte, input empty_packet, input aborted, output ready);
endinterface

// ===== rtl/length_prefix_deframer_per_conn.sv =====
// top level of the per-connection two-byte length prefix deframer
//
// in_i carries one transaction per received stream byte (op = data) or per
// close/error event (op = close), tagged with conn_id. out_o carries one
// transaction per payload byte, with first_byte and last_byte marking packet
// edges; a zero-length packet gives a single empty_packet transaction and a
// close during a partly delivered packet gives an aborted transaction.
// Header bytes and silent closes give no output transaction.
//
// Throughput is one input transaction per cycle while out_o is not stalled,
// set by the single read-modify-write pass over the connection record ram
// (one read port, one write port). A result reaches out_o through the ram
// read register and then the output register after its input is accepted.
//
// Reset returns every connection to awaiting its high length byte at once:
// a valid bit per record marks entries written since reset.
// When the receiver holds out_o.ready low, the output register keeps its
// transaction, the record stage holds, and in_i.ready drops only while both
// are full.
module length_prefix_deframer_per_conn #(
  parameter int CONNECTIONS = lpd_pkg::CONN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpd_in_if.sink     in_i,
  lpd_out_if.source  out_o
);

  // only connection numbers that fit the 8-bit id need a record
  localparam int DEPTH = (CONNECTIONS < lpd_pkg::CONN_ID_MAX) ? CONNECTIONS
                                                              : lpd_pkg::CONN_ID_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [16:0] CONN_LIM = 17'(CONNECTIONS);

  typedef lpd_pkg::entry_t entry_t;

  // input side
  logic          in_acc;
  logic          in_range;
  logic [AW-1:0] in_idx;

  // record stage
  logic                        s1_vld_q, s1_vld_d;
  logic                        s1_op_q;
  logic [lpd_pkg::ID_W-1:0]    s1_conn_q;
  logic [lpd_pkg::BYTE_W-1:0]  s1_byte_q;
  logic                        s1_inr_q;
  logic                        s1_seen_q;
  logic                        s1_adv;
  logic [AW-1:0]               s1_idx;

  // record valid bits, cleared at reset
  logic [DEPTH-1:0] seen_q, seen_d;

  // bypass of the write made at the edge of the current read
  logic          byp_vld_q, byp_vld_d;
  logic [AW-1:0] byp_addr_q;
  entry_t        byp_data_q;
  logic          byp_hit;

  logic [lpd_pkg::ENTRY_W-1:0] ram_rdata;
  entry_t cur;
  entry_t nxt;
  logic   wr_en;

  // result of the record stage
  logic                        res_vld;
  logic [lpd_pkg::BYTE_W-1:0]  res_byte;
  logic                        res_first;
  logic                        res_last;
  logic                        res_empty;
  logic                        res_abort;
  logic [lpd_pkg::LEN_W-1:0]   len_cnt;
  logic [lpd_pkg::LEN_W-1:0]   dec_cnt;

  // output register
  logic                        out_vld_q, out_vld_d;
  logic [lpd_pkg::ID_W-1:0]    out_conn_q;
  logic [lpd_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_first_q;
  logic                        out_last_q;
  logic                        out_empty_q;
  logic                        out_abort_q;

  // the record stage moves on when it is empty or its result has a place
  assign s1_adv   = !s1_vld_q || !out_vld_q || out_o.ready;
  assign in_i.ready = s1_adv;
  assign in_acc   = in_i.valid && s1_adv;
  assign in_range = (17'(in_i.conn_id) < CONN_LIM);
  assign in_idx   = in_i.conn_id[AW-1:0];
  assign s1_idx   = s1_conn_q[AW-1:0];

  lpd_ram #(
    .WIDTH (lpd_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (nxt),
    .re_i    (in_acc && in_range),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // current record: bypass first, then ram, else the reset value
  assign byp_hit = byp_vld_q && (byp_addr_q == s1_idx);

  always_comb begin
    if (byp_hit) begin
      cur = byp_data_q;
    end else if (s1_seen_q) begin
      cur = entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  // record update and result
  always_comb begin
    nxt       = '0;
    res_vld   = 1'b0;
    res_byte  = '0;
    res_first = 1'b0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_abort = 1'b0;
    len_cnt   = {cur.count[lpd_pkg::LEN_W-1:lpd_pkg::BYTE_W], s1_byte_q};
    dec_cnt   = cur.count - lpd_pkg::LEN_W'(1);
    if (s1_op_q == lpd_pkg::OP_CLOSE) begin
      // close: drop the record, flag an abort if bytes already went out
      if (cur.phase == lpd_pkg::PH_BODY) begin
        res_vld   = 1'b1;
        res_last  = 1'b1;
        res_abort = 1'b1;
      end
    end else begin
      case (cur.phase)
        lpd_pkg::PH_HIGH: begin
          nxt.phase = lpd_pkg::PH_LOW;
          nxt.count = {s1_byte_q, lpd_pkg::BYTE_W'(0)};
        end
        lpd_pkg::PH_LOW: begin
          if (len_cnt == '0) begin
            // zero-length packet
            res_vld   = 1'b1;
            res_first = 1'b1;
            res_last  = 1'b1;
            res_empty = 1'b1;
          end else begin
            nxt.phase = lpd_pkg::PH_START;
            nxt.count = len_cnt;
          end
        end
        lpd_pkg::PH_START, lpd_pkg::PH_BODY: begin
          res_vld   = 1'b1;
          res_byte  = s1_byte_q;
          res_first = (cur.phase == lpd_pkg::PH_START);
          res_last  = (dec_cnt == '0);
          nxt.count = dec_cnt;
          nxt.phase = (dec_cnt == '0) ? lpd_pkg::PH_HIGH : lpd_pkg::PH_BODY;
        end
        default: begin
          nxt = '0;
        end
      endcase
    end
    if (!s1_inr_q) begin
      res_vld = 1'b0;
    end
  end

  assign wr_en = s1_vld_q && s1_inr_q && s1_adv;

  always_comb begin
    s1_vld_d  = s1_adv ? in_acc : s1_vld_q;
    byp_vld_d = s1_adv ? wr_en : byp_vld_q;
    seen_d    = seen_q;
    if (wr_en) begin
      seen_d[s1_idx] = 1'b1;
    end
    out_vld_d = out_vld_q && !out_o.ready;
    if (s1_vld_q && s1_adv && res_vld) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      seen_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      byp_vld_q <= byp_vld_d;
      seen_q    <= seen_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q   <= in_i.op;
      s1_conn_q <= in_i.conn_id;
      s1_byte_q <= in_i.data_byte;
      s1_inr_q  <= in_range;
      s1_seen_q <= in_range && seen_q[in_idx];
    end
    if (wr_en) begin
      byp_addr_q <= s1_idx;
      byp_data_q <= nxt;
    end
    if (s1_vld_q && s1_adv && res_vld) begin
      out_conn_q  <= s1_conn_q;
      out_byte_q  <= res_byte;
      out_first_q <= res_first;
      out_last_q  <= res_last;
      out_empty_q <= res_empty;
      out_abort_q <= res_abort;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.out_conn     = out_conn_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.first_byte   = out_first_q;
  assign out_o.last_byte    = out_last_q;
  assign out_o.empty_packet = out_empty_q;
  assign out_o.aborted      = out_abort_q;

  // an accepted transaction sits in the record stage next cycle
  a_acc_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("accepted transaction missing from record stage");

  // the bypass only turns valid at the edge of a record write
  a_byp_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byp_vld_q && !$past(byp_vld_q)) |-> $past(wr_en))
    else $error("bypass valid without a write");

  // an abort result never carries first or empty markers
  a_abort_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_abort_q) |-> (out_last_q && !out_first_q && !out_empty_q))
    else $error("abort result with bad markers");

  // records are written only for connections in range
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (s1_vld_q && s1_inr_q))
    else $error("record write for out of range connection");

endmodule

// ===== rtl/lpd_ram.sv =====
// generic simple dual port ram with registered read
module lpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
